[hdl/wbps_pkg.sv]
// Shared constants, register codes and types for the wildcard byte pattern scanner.
package wbps_pkg;

  // Pattern geometry
  localparam int MaxPattern = 24;
  localparam int IdxW       = $clog2(MaxPattern);
  localparam int ByteW      = 8;
  localparam int LenW       = 5;
  localparam int PatWords   = 3;
  localparam int PatWordW   = 64;

  // Per-image tracking widths
  localparam int PosW   = 32;
  localparam int CountW = 16;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // Result packing: match_here, match_offset, match_count, exactly_one, then zero fill
  localparam int OutFieldW = 1 + PosW + CountW + 1;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int InDataW   = ByteW;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_FIRST  = 3'd0,
    REG_PAT_SECOND = 3'd1,
    REG_PAT_THIRD  = 3'd2,
    REG_WILD_MASK  = 3'd3,
    REG_PAT_LEN    = 3'd4
  } cfg_reg_t;

  // Pattern laid out against the window taps: tap j faces the byte j steps back
  typedef struct packed {
    logic [IdxW-1:0]                  last_idx;
    logic [MaxPattern-1:0][ByteW-1:0] tap_byte;
    logic [MaxPattern-1:0]            tap_wild;
  } taps_t;

  // Status of the window stage as seen by the match stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

[hdl/wildcard_byte_pattern_scanner_unit.sv]
// Top level of the wildcard byte pattern scanner.
//
//  channel | dir | handshake                | payload
//  in      | in  | in_tvalid / in_tready    | in_tdata[7:0] byte, in_tlast end of image
//  out     | out | out_tvalid / out_tready  | out_tdata match result, out_tlast end of image
//  cfg     | in  | cfg_valid / cfg_ready    | cfg_index register, cfg_data value
//
// One result per byte, one byte per cycle sustained while out_tready holds high; the byte is
// registered in the window register, then its result in the result register, before it transfers.
// The tap comparators plus the 32-bit position compare set the cycle.
// Pattern changes take effect once the derived tap register is loaded from the written registers.
// Reset clears the pattern (length one, no wildcards) and the per-image counters.
// A stalled result holds; the window stage keeps its byte until the result register frees.
module wildcard_byte_pattern_scanner_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wbps_pkg::InDataW-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wbps_pkg::OutDataW-1:0] out_tdata,  // [0] match_here, [32:1] match_offset,
                                                    // [48:33] match_count, [49] exactly_one
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_data
);
  import wbps_pkg::*;

  taps_t                            taps;
  stage_ctl_t                       ctl;
  logic [MaxPattern-1:0][ByteW-1:0] window;
  logic                             advance;
  logic                             take;

  // Input transfer whenever the window stage is empty or moving on
  assign in_tready = !ctl.valid || advance;
  assign take      = in_tvalid && in_tready;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .taps      (taps)
  );

  wbps_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .drain     (advance),
    .data_byte (in_tdata[ByteW-1:0]),
    .last_byte (in_tlast),
    .window    (window),
    .ctl       (ctl)
  );

  wbps_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .window    (window),
    .ctl       (ctl),
    .taps      (taps),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

[hdl/wbps_cfg.sv]
// Configuration registers and the derived per-tap pattern used by the comparators.
module wbps_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_data,
  output wbps_pkg::taps_t               taps
);
  import wbps_pkg::*;

  logic [PatWords-1:0][PatWordW-1:0] pat_word_r;
  logic [MaxPattern-1:0]             wild_r;
  logic [LenW-1:0]                   len_r;
  taps_t                             taps_r, taps_nxt;

  logic [PatWords*PatWordW-1:0] pat_flat;
  logic [LenW-1:0]              len_clamp;
  logic [IdxW-1:0]              lim;
  logic [IdxW-1:0]              eff;

  assign cfg_ready = 1'b1;
  assign pat_flat  = pat_word_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_word_r <= '0;
      wild_r     <= '0;
      len_r      <= LenW'(1);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_FIRST:  pat_word_r[0] <= cfg_data;
        REG_PAT_SECOND: pat_word_r[1] <= cfg_data;
        REG_PAT_THIRD:  pat_word_r[2] <= cfg_data;
        REG_WILD_MASK:  wild_r        <= cfg_data[MaxPattern-1:0];
        REG_PAT_LEN:    len_r         <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length, then trim trailing wildcards down to the last fixed position
  always_comb begin
    len_clamp = len_r;
    if (len_r == '0) len_clamp = LenW'(1);
    if (len_r > LenW'(MaxPattern)) len_clamp = LenW'(MaxPattern);
    lim = IdxW'(len_clamp - LenW'(1));
    eff = '0;
    for (int j = 1; j < MaxPattern; j++) begin
      if (IdxW'(j) <= lim && !wild_r[j]) eff = IdxW'(j);
    end
  end

  // Tap j compares against pattern position eff - j; taps beyond eff are don't-care
  always_comb begin
    taps_nxt.last_idx = eff;
    for (int j = 0; j < MaxPattern; j++) begin
      taps_nxt.tap_byte[j] = '0;
      taps_nxt.tap_wild[j] = 1'b1;
      for (int i = 0; i < MaxPattern; i++) begin
        if ((i + j) == int'(eff)) begin
          taps_nxt.tap_byte[j] = pat_flat[i*ByteW +: ByteW];
          taps_nxt.tap_wild[j] = wild_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r.last_idx <= '0;
      taps_r.tap_byte <= '0;
      taps_r.tap_wild <= {{(MaxPattern-1){1'b1}}, 1'b0};
    end else begin
      taps_r <= taps_nxt;
    end
  end

  assign taps = taps_r;

endmodule

[hdl/wbps_window.sv]
// Input register: shift window of recent bytes plus the end-of-image flag.
module wbps_window (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                take,
  input  logic                                                drain,
  input  logic [wbps_pkg::ByteW-1:0]                          data_byte,
  input  logic                                                last_byte,
  output logic [wbps_pkg::MaxPattern-1:0][wbps_pkg::ByteW-1:0] window,
  output wbps_pkg::stage_ctl_t                                ctl
);
  import wbps_pkg::*;

  logic [MaxPattern-1:0][ByteW-1:0] window_r;
  logic                             valid_r;
  logic                             last_r;

  // Window shifts on every accepted byte, newest at tap 0
  always_ff @(posedge clk) begin
    if (take) begin
      window_r <= {window_r[MaxPattern-2:0], data_byte};
      last_r   <= last_byte;
    end
  end

  // Stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (drain) begin
      valid_r <= 1'b0;
    end
  end

  assign window    = window_r;
  assign ctl.valid = valid_r;
  assign ctl.last  = last_r;

endmodule

[hdl/wbps_track.sv]
// Tap comparators, per-image position/offset/count tracking and the result register.
module wbps_track (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic [wbps_pkg::MaxPattern-1:0][wbps_pkg::ByteW-1:0] window,
  input  wbps_pkg::stage_ctl_t                                ctl,
  input  wbps_pkg::taps_t                                     taps,
  output logic                                                advance,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic [wbps_pkg::OutDataW-1:0]                       out_data,
  output logic                                                out_last
);
  import wbps_pkg::*;

  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [PosW-1:0]   latest_r, latest_nxt;
  logic [CountW-1:0] count_r, count_nxt;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [PosW-1:0]       out_offset_r;
  logic [CountW-1:0]     out_count_r;
  logic                  out_one_r;
  logic                  out_last_r;

  logic [MaxPattern-1:0] tap_ok;
  logic                  hit;
  logic [PosW-1:0]       res_offset;
  logic [CountW-1:0]     res_count;

  // Result register frees up when empty or being taken
  assign advance = ctl.valid && (!out_valid_r || out_ready);

  // One comparator per tap
  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      tap_ok[j] = taps.tap_wild[j] || (taps.tap_byte[j] == window[j]);
    end
  end

  // A match needs enough bytes of this image in the window
  assign hit = (pos_r >= PosW'(taps.last_idx)) && (&tap_ok);

  always_comb begin
    res_offset = latest_r;
    res_count  = count_r;
    if (hit) begin
      res_offset = pos_r - PosW'(taps.last_idx);
      if (count_r != {CountW{1'b1}}) res_count = count_r + CountW'(1);
    end
  end

  // Per-image state restarts after the last byte
  always_comb begin
    pos_nxt    = pos_r + PosW'(1);
    latest_nxt = res_offset;
    count_nxt  = res_count;
    if (ctl.last) begin
      pos_nxt    = '0;
      latest_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      latest_r <= '0;
      count_r  <= '0;
    end else if (advance) begin
      pos_r    <= pos_nxt;
      latest_r <= latest_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r    <= hit;
      out_offset_r <= res_offset;
      out_count_r  <= res_count;
      out_one_r    <= (res_count == CountW'(1));
      out_last_r   <= ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_data  = {{(OutDataW-OutFieldW){1'b0}},
                      out_one_r, out_count_r, out_offset_r, out_hit_r};

endmodule

[bench/scan_result_checker.sv]
// Checker for the pattern scanner: models the scan, queues the expected results and compares them.
`timescale 1ns / 1ps

module scan_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [wbps_pkg::InDataW-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [wbps_pkg::OutDataW-1:0] out_tdata,  // [0] match_here, [32:1] match_offset,
                                                    // [48:33] match_count, [49] exactly_one
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_data,
  output int                            mismatches,
  output int                            awaiting
);
  import wbps_pkg::*;

  typedef struct packed {
    logic              match_here;
    logic [PosW-1:0]   match_offset;
    logic [CountW-1:0] match_count;
    logic              exactly_one;
    logic              end_of_image;
  } scan_result_t;

  // Register copies
  logic [PatWordW-1:0]   pat_word [PatWords];
  logic [MaxPattern-1:0] wild_bits;
  logic [LenW-1:0]       pat_len;

  // Per-image scan state
  logic [ByteW-1:0]  window [MaxPattern];
  logic [PosW-1:0]   image_pos;
  logic [PosW-1:0]   latest_start;
  logic [CountW-1:0] hit_count;

  scan_result_t expected_results [$];

  // Index of the last pattern position that is not a wildcard, length clamped to 1..24
  function automatic int trimmed_last();
    int len;
    int e;
    len = pat_len;
    if (len < 1) len = 1;
    if (len > MaxPattern) len = MaxPattern;
    e = len - 1;
    while (e > 0 && wild_bits[e]) e--;
    return e;
  endfunction

  function automatic logic [ByteW-1:0] pattern_byte(int i);
    return pat_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  task automatic check_field(input string name, input logic [PosW-1:0] want,
                             input logic [PosW-1:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    int e;
    int i;
    int k;
    logic hit;
    scan_result_t want;
    scan_result_t seen;
    if (!rst_n) begin
      for (k = 0; k < PatWords; k++) pat_word[k] = '0;
      for (k = 0; k < MaxPattern; k++) window[k] = '0;
      wild_bits    = '0;
      pat_len      = LenW'(1);
      image_pos    = '0;
      latest_start = '0;
      hit_count    = '0;
      mismatches   = 0;
      expected_results.delete();
      awaiting <= 0;
    end else begin
      // Register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PAT_FIRST:  pat_word[0] = cfg_data;
          REG_PAT_SECOND: pat_word[1] = cfg_data;
          REG_PAT_THIRD:  pat_word[2] = cfg_data;
          REG_WILD_MASK:  wild_bits   = cfg_data[MaxPattern-1:0];
          REG_PAT_LEN:    pat_len     = cfg_data[LenW-1:0];
          default: ;
        endcase
      end

      // Byte transfer: shift the window, try the alignment ending here
      if (in_tvalid && in_tready) begin
        e = trimmed_last();
        for (k = MaxPattern - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = in_tdata[ByteW-1:0];
        hit = (image_pos >= e);
        for (i = 0; i <= e; i++) begin
          if (!wild_bits[i] && pattern_byte(i) != window[e-i]) hit = 1'b0;
        end
        if (hit) begin
          latest_start = image_pos - e;
          if (hit_count != '1) hit_count++;
        end
        want = '{hit, latest_start, hit_count, (hit_count == CountW'(1)), in_tlast};
        expected_results.insert(expected_results.size(), want);
        image_pos++;
        if (in_tlast) begin
          image_pos    = '0;
          latest_start = '0;
          hit_count    = '0;
        end
      end

      // Result transfer: compare with the oldest expectation
      if (out_tvalid && out_tready) begin
        seen = '{out_tdata[0], out_tdata[32:1], out_tdata[48:33], out_tdata[49], out_tlast};
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("match_here",   want.match_here,   seen.match_here);
          check_field("match_offset", want.match_offset, seen.match_offset);
          check_field("match_count",  want.match_count,  seen.match_count);
          check_field("exactly_one",  want.exactly_one,  seen.exactly_one);
          check_field("end_of_image", want.end_of_image, seen.end_of_image);
        end
      end
      awaiting <= expected_results.size();
    end
  end

endmodule

[bench/tb_wildcard_byte_pattern_scanner_unit.sv]
// Testbench top for the pattern scanner: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_unit;
  import wbps_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int MaxGap     = 12;
  localparam int RandBytes  = 680;
  localparam int RegTop     = (1 << CfgIdxW) - 1;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // [7:0] data_byte
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // [0] match_here, [32:1] match_offset,
                                   // [48:33] match_count, [49] exactly_one
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int mismatches;
  int awaiting;
  int cycles;
  int bytes_sent;
  bit steady;  // set: neither side idles

  // Pattern as last written, used to build matching images
  logic [PatWordW-1:0]   pat_tb [PatWords];
  logic [MaxPattern-1:0] wild_tb;
  logic [LenW-1:0]       len_tb;

  wildcard_byte_pattern_scanner_unit dut (.*);

  scan_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_wildcard_byte_pattern_scanner_unit failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (steady) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  function automatic logic [ByteW-1:0] pat_at(int i);
    return pat_tb[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // Positions up to the last non-wildcard one
  function automatic int pattern_span();
    int len;
    len = len_tb;
    if (len < 1) len = 1;
    if (len > MaxPattern) len = MaxPattern;
    while (len > 1 && wild_tb[len-1]) len--;
    return len;
  endfunction

  // Result side: random stall before each transfer
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    bytes_sent++;
  endtask

  // Wait until every result is out, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // Full register set; a write to an unused index goes first and must be dropped
  task automatic configure(input logic [63:0] w0, input logic [63:0] w1,
                           input logic [63:0] w2, input logic [63:0] mask,
                           input logic [63:0] len);
    settle();
    write_reg(CfgIdxW'($urandom_range(REG_PAT_LEN + 1, RegTop)), {$urandom, $urandom});
    write_reg(REG_PAT_FIRST, w0);
    write_reg(REG_PAT_SECOND, w1);
    write_reg(REG_PAT_THIRD, w2);
    write_reg(REG_WILD_MASK, mask);
    write_reg(REG_PAT_LEN, len);
    cfg_valid <= 1'b0;
    pat_tb[0] = w0;
    pat_tb[1] = w1;
    pat_tb[2] = w2;
    wild_tb   = mask[MaxPattern-1:0];
    len_tb    = len[LenW-1:0];
    // wait for the taps to be rebuilt from the written registers
    repeat (2) @(posedge clk);
  endtask

  task automatic random_setup();
    logic [63:0] mask;
    logic [63:0] len;
    mask = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       mask[MaxPattern-1:0] = '0;
      1:       mask[MaxPattern-1:0] = '1;
      default: mask[MaxPattern-1:0] = $urandom & $urandom;
    endcase
    len = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       len[LenW-1:0] = 1;
      1:       len[LenW-1:0] = MaxPattern;
      2:       len[LenW-1:0] = 0;
      3:       len[LenW-1:0] = $urandom_range(MaxPattern + 1, 31);
      default: len[LenW-1:0] = $urandom_range(1, MaxPattern);
    endcase
    configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, mask, len);
  endtask

  // One image: embedded copies of the pattern (some broken) over a background
  // drawn partly from the pattern's own bytes, so near misses are common
  task automatic send_image(input int len, input int density);
    int span;
    int sent;
    int i;
    int flaw;
    logic [ByteW-1:0] b;
    span = pattern_span();
    sent = 0;
    while (sent < len) begin
      if ($urandom_range(0, 99) < density && sent + span <= len) begin
        flaw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span - 1) : -1;
        for (i = 0; i < span; i++) begin
          b = wild_tb[i] ? ByteW'($urandom) : pat_at(i);
          if (i == flaw) b ^= ByteW'(1 << $urandom_range(0, ByteW - 1));
          send_byte(b, sent == len - 1);
          sent++;
        end
      end else begin
        b = $urandom_range(0, 1) ? ByteW'($urandom) : pat_at($urandom_range(0, span - 1));
        send_byte(b, sent == len - 1);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int span;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    steady     = 1'b0;
    bytes_sent = 0;
    pat_tb[0]  = '0;
    pat_tb[1]  = '0;
    pat_tb[2]  = '0;
    wild_tb    = '0;
    len_tb     = LenW'(1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern: single zero byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // DE AD ?? EF: two matches, then a short image and one split across images
    configure(64'h0000_0000_EF00_ADDE, '0, '0, 64'h4, 64'd4);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hEF, 1'b1);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hEF, 1'b1);

    // All wildcards, length zero, junk above the register widths
    configure('1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFE0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);

    // Trailing wildcards trimmed: 11 22 33 44 ?? ?? matches at the image end
    configure(64'h0000_0000_4433_2211, '0, '0, 64'h30, 64'd6);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);

    // Random phases until the byte budget is spent
    while (bytes_sent < RandBytes) begin
      random_setup();
      span = pattern_span();
      repeat ($urandom_range(2, 6)) begin
        if (bytes_sent < RandBytes) begin
          steady = ($urandom_range(0, 5) == 0);
          send_image($urandom_range(1, 3 * span + 8), $urandom_range(5, 60));
        end
      end
      steady = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_wildcard_byte_pattern_scanner_unit passed");
    end else begin
      $display("tb_wildcard_byte_pattern_scanner_unit failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/wbps_pkg.sv
hdl/wbps_cfg.sv
hdl/wbps_window.sv
hdl/wbps_track.sv
hdl/wildcard_byte_pattern_scanner_unit.sv
bench/scan_result_checker.sv
bench/tb_wildcard_byte_pattern_scanner_unit.sv
